### sv/kmd_pkg.sv
// ----------------------------------------------------------------------------
// kmd_pkg
// Shared types and constants for the k-way merge with duplicate removal.
// ----------------------------------------------------------------------------
package kmd_pkg;

   localparam int KEY_W    = 64;
   localparam int REQ_W    = 2;
   localparam int SEL_W    = 3;
   localparam int STATUS_W = 2;
   localparam int LIU_W    = 4;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   localparam logic [LIU_W-1:0] LIU_RESET        = 4'd8;
   localparam logic             CSR_LISTS_IN_USE = 1'b0;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_CLEAR = 2'd2
   } kmd_req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_EMIT = 2'd2,
      ST_DONE = 2'd3
   } kmd_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_CONSUME,
      S_FINISH
   } kmd_state_type;

   typedef struct packed {
      logic inc_fill;
      logic inc_read;
      logic clear_all;
   } kmd_ptr_op_type;

   typedef struct packed {
      logic has_key;
      logic full;
   } kmd_ptr_stat_type;

endpackage

### sv/kmd_ifs.sv
// ----------------------------------------------------------------------------
// kmd_req_if / kmd_rsp_if
// Valid/ready channels for merge requests and their results.
// ----------------------------------------------------------------------------
interface kmd_req_if;
   logic                         valid;
   logic                         ready;
   logic [kmd_pkg::REQ_W-1:0]    req_type;
   logic [kmd_pkg::SEL_W-1:0]    list_select;
   logic [kmd_pkg::KEY_W-1:0]    key_in;

   modport source (output valid, output req_type, output list_select, output key_in,
                   input ready);
   modport sink   (input valid, input req_type, input list_select, input key_in,
                   output ready);
endinterface

interface kmd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [kmd_pkg::KEY_W-1:0]    key_out;
   logic [kmd_pkg::STATUS_W-1:0] status;

   modport source (output valid, output key_out, output status, input ready);
   modport sink   (input valid, input key_out, input status, output ready);
endinterface

### sv/kway_merge_dedup_core.sv
// ----------------------------------------------------------------------------
// kway_merge_dedup_core
// Merges sorted key lists into one ascending stream without repeats.
// ----------------------------------------------------------------------------
// Requests arrive on req_ch (load a key into a list, pop the next merged key,
// clear all lists); each request yields exactly one result on rsp_ch with
// key_out and status. lists_in_use is written over the APB port (byte
// address 0); the user must write it only while the block is idle, as the block does not enforce this.
// Keys live in one synchronous RAM of LISTS x LIST_DEPTH entries; fill counts
// and read positions sit in flops. Load, clear: the result is registered, then
// moved to the output register. Pop: one pass over the heads reads the RAM once
// per active list, then drains and consumes; a pop makes one pass per
// duplicate head skipped plus one that emits or finds the lists empty, then
// moves its result to the output register.
// One request is worked on at a time; a new request is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// A stalled receiver holds the result register and the next result waits.
// Reset empties all lists, clears the last emitted key and sets lists_in_use
// to 8; no clearing pass is needed.
// ----------------------------------------------------------------------------
module kway_merge_dedup_core #(
   parameter int LISTS      = 8,
   parameter int LIST_DEPTH = 1024,
   parameter int KEY_BITS   = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   kmd_req_if.sink                       req_ch,
   kmd_rsp_if.source                     rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [kmd_pkg::PADDR_W-1:0]   paddr,
   input  logic [kmd_pkg::PDATA_W-1:0]   pwdata,
   output logic [kmd_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);

   localparam int LW        = $clog2(LISTS);
   localparam int PW        = $clog2(LIST_DEPTH);
   localparam int CW        = $clog2(LISTS + 1);
   localparam int AW        = LW + PW;
   localparam int MEM_DEPTH = LISTS * (2 ** PW);

   kmd_pkg::kmd_state_type     state_ff, state_in;
   kmd_pkg::kmd_req_code_type  req_code;
   kmd_pkg::kmd_ptr_op_type    ptr_op;
   kmd_pkg::kmd_ptr_stat_type  ptr_stat;

   logic [kmd_pkg::LIU_W-1:0]    liu_ff, liu_in;
   logic [CW-1:0]                active;
   logic [LW-1:0]                ptr_addr;
   logic [PW-1:0]                head_pos;
   logic [PW-1:0]                tail_pos;
   logic [LW-1:0]                sel_idx;
   logic                         sel_ok;

   logic [LW-1:0]                scan_idx_ff, scan_idx_in;
   logic                         tag_valid_ff, tag_valid_in;
   logic [LW-1:0]                tag_idx_ff, tag_idx_in;
   logic                         best_valid_ff, best_valid_in;
   logic [LW-1:0]                best_idx_ff, best_idx_in;
   logic [KEY_BITS-1:0]          best_key_ff, best_key_in;
   logic [KEY_BITS-1:0]          last_key_ff, last_key_in;
   logic                         have_ff, have_in;
   logic [kmd_pkg::KEY_W-1:0]    res_key_ff, res_key_in;
   kmd_pkg::kmd_status_type      res_status_ff, res_status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kmd_pkg::KEY_W-1:0]    rsp_key_ff, rsp_key_in;
   kmd_pkg::kmd_status_type      rsp_status_ff, rsp_status_in;

   logic [KEY_BITS-1:0]          mem [MEM_DEPTH];
   logic [KEY_BITS-1:0]          rd_data_ff;
   logic [AW-1:0]                mem_raddr;
   logic [AW-1:0]                mem_waddr;
   logic                         mem_we;
   logic                         req_acc;
   logic                         rsp_free;
   logic                         csr_wr;

   // Configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == kmd_pkg::CSR_LISTS_IN_USE);
   assign liu_in = csr_wr ? pwdata[kmd_pkg::LIU_W-1:0] : liu_ff;
   assign prdata = (paddr[2] == kmd_pkg::CSR_LISTS_IN_USE) ?
                   kmd_pkg::PDATA_W'(liu_ff) : '0;

   assign active   = (32'(liu_ff) > LISTS) ? CW'(LISTS) : CW'(liu_ff);
   assign sel_ok   = 32'(req_ch.list_select) < LISTS;
   assign sel_idx  = LW'(req_ch.list_select);
   assign req_code = kmd_pkg::kmd_req_code_type'(req_ch.req_type);

   assign req_ch.ready  = (state_ff == kmd_pkg::S_IDLE);
   assign req_acc       = req_ch.valid && req_ch.ready;
   assign rsp_free      = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.key_out = rsp_key_ff;
   assign rsp_ch.status = rsp_status_ff;

   assign mem_waddr = {sel_idx, tail_pos};

   kmd_ptr_file #(
      .LISTS      (LISTS),
      .LIST_DEPTH (LIST_DEPTH)
   ) u_ptr_file (
      .clock    (clock),
      .reset    (reset),
      .addr     (ptr_addr),
      .op       (ptr_op),
      .head_pos (head_pos),
      .tail_pos (tail_pos),
      .stat     (ptr_stat)
   );

   // Key store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= KEY_BITS'(req_ch.key_in);
      end
      rd_data_ff <= mem[mem_raddr];
   end

   always_comb begin
      state_in      = state_ff;
      ptr_op        = '0;
      mem_we        = 1'b0;
      mem_raddr     = {scan_idx_ff, head_pos};
      scan_idx_in   = scan_idx_ff;
      tag_valid_in  = 1'b0;
      tag_idx_in    = tag_idx_ff;
      best_valid_in = best_valid_ff;
      best_idx_in   = best_idx_ff;
      best_key_in   = best_key_ff;
      last_key_in   = last_key_ff;
      have_in       = have_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_key_in    = rsp_key_ff;
      rsp_status_in = rsp_status_ff;

      // head compare, one list per cycle; strict less keeps the lowest index on ties
      if (tag_valid_ff && (!best_valid_ff || rd_data_ff < best_key_ff)) begin
         best_valid_in = 1'b1;
         best_idx_in   = tag_idx_ff;
         best_key_in   = rd_data_ff;
      end

      unique case (state_ff)
         kmd_pkg::S_IDLE: begin
            ptr_addr = sel_idx;
            if (req_acc) begin
               res_key_in    = '0;
               res_status_in = kmd_pkg::ST_OK;
               state_in      = kmd_pkg::S_FINISH;
               unique case (req_code)
                  kmd_pkg::REQ_LOAD: begin
                     if (!sel_ok || ptr_stat.full) begin
                        res_status_in = kmd_pkg::ST_FULL;
                     end else begin
                        mem_we          = 1'b1;
                        ptr_op.inc_fill = 1'b1;
                     end
                  end
                  kmd_pkg::REQ_POP: begin
                     scan_idx_in   = '0;
                     best_valid_in = 1'b0;
                     state_in      = kmd_pkg::S_SCAN;
                  end
                  kmd_pkg::REQ_CLEAR: begin
                     ptr_op.clear_all = 1'b1;
                     last_key_in      = '0;
                     have_in          = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         kmd_pkg::S_SCAN: begin
            ptr_addr = scan_idx_ff;
            if (active == '0) begin
               state_in = kmd_pkg::S_CONSUME;
            end else begin
               tag_valid_in = ptr_stat.has_key;
               tag_idx_in   = scan_idx_ff;
               if ((CW'(scan_idx_ff) + CW'(1)) == active) begin
                  state_in = kmd_pkg::S_DRAIN;
               end else begin
                  scan_idx_in = scan_idx_ff + LW'(1);
               end
            end
         end
         kmd_pkg::S_DRAIN: begin
            ptr_addr = scan_idx_ff;
            state_in = kmd_pkg::S_CONSUME;
         end
         kmd_pkg::S_CONSUME: begin
            ptr_addr = best_idx_ff;
            if (!best_valid_ff) begin
               res_key_in    = '0;
               res_status_in = kmd_pkg::ST_DONE;
               state_in      = kmd_pkg::S_FINISH;
            end else begin
               ptr_op.inc_read = 1'b1;
               if (have_ff && best_key_ff == last_key_ff) begin
                  scan_idx_in   = '0;
                  best_valid_in = 1'b0;
                  state_in      = kmd_pkg::S_SCAN;
               end else begin
                  last_key_in   = best_key_ff;
                  have_in       = 1'b1;
                  res_key_in    = kmd_pkg::KEY_W'(best_key_ff);
                  res_status_in = kmd_pkg::ST_EMIT;
                  state_in      = kmd_pkg::S_FINISH;
               end
            end
         end
         kmd_pkg::S_FINISH: begin
            ptr_addr = scan_idx_ff;
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_key_in    = res_key_ff;
               rsp_status_in = res_status_ff;
               state_in      = kmd_pkg::S_IDLE;
            end
         end
         default: begin
            ptr_addr = scan_idx_ff;
            state_in = kmd_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kmd_pkg::S_IDLE;
         liu_ff        <= kmd_pkg::LIU_RESET;
         scan_idx_ff   <= '0;
         tag_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         last_key_ff   <= '0;
         have_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         liu_ff        <= liu_in;
         scan_idx_ff   <= scan_idx_in;
         tag_valid_ff  <= tag_valid_in;
         best_valid_ff <= best_valid_in;
         last_key_ff   <= last_key_in;
         have_ff       <= have_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_idx_ff    <= tag_idx_in;
      best_idx_ff   <= best_idx_in;
      best_key_ff   <= best_key_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef SYNTHESIS
   a_finish_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kmd_pkg::S_FINISH && !rsp_valid_ff) |=> (state_ff == kmd_pkg::S_IDLE))
      else $error("result not moved to free output register");

   a_best_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kmd_pkg::S_CONSUME && best_valid_ff) |-> (32'(best_idx_ff) < 32'(active)))
      else $error("selected list outside the active set");

   a_dup_rescans: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kmd_pkg::S_CONSUME && best_valid_ff && have_ff &&
       best_key_ff == last_key_ff) |=> (state_ff == kmd_pkg::S_SCAN && !best_valid_ff))
      else $error("duplicate head not skipped");
`endif

endmodule

### sv/kmd_ptr_file.sv
// ----------------------------------------------------------------------------
// kmd_ptr_file
// Per-list fill counts and read positions, one shared read/update port.
// ----------------------------------------------------------------------------
module kmd_ptr_file #(
   parameter int LISTS      = 8,
   parameter int LIST_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(LISTS)-1:0]          addr,
   input  kmd_pkg::kmd_ptr_op_type           op,
   output logic [$clog2(LIST_DEPTH)-1:0]     head_pos,
   output logic [$clog2(LIST_DEPTH)-1:0]     tail_pos,
   output kmd_pkg::kmd_ptr_stat_type         stat
);

   localparam int PW = $clog2(LIST_DEPTH);
   localparam int FW = $clog2(LIST_DEPTH + 1);

   logic [FW-1:0] fill_ff [LISTS];
   logic [FW-1:0] fill_in [LISTS];
   logic [FW-1:0] rpos_ff [LISTS];
   logic [FW-1:0] rpos_in [LISTS];
   logic [FW-1:0] fill_sel;
   logic [FW-1:0] rpos_sel;

   assign fill_sel     = fill_ff[addr];
   assign rpos_sel     = rpos_ff[addr];
   assign head_pos     = rpos_sel[PW-1:0];
   assign tail_pos     = fill_sel[PW-1:0];
   assign stat.has_key = rpos_sel < fill_sel;
   assign stat.full    = fill_sel == FW'(LIST_DEPTH);

   always_comb begin
      fill_in = fill_ff;
      rpos_in = rpos_ff;
      if (op.clear_all) begin
         for (int i = 0; i < LISTS; i++) begin
            fill_in[i] = '0;
            rpos_in[i] = '0;
         end
      end else begin
         if (op.inc_fill) begin
            fill_in[addr] = fill_sel + FW'(1);
         end
         if (op.inc_read) begin
            rpos_in[addr] = rpos_sel + FW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LISTS; i++) begin
            fill_ff[i] <= '0;
            rpos_ff[i] <= '0;
         end
      end else begin
         fill_ff <= fill_in;
         rpos_ff <= rpos_in;
      end
   end

endmodule
